// ----- hdl/ctb_pkg.sv -----
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and constants for the countdown timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

   // bank geometry
   localparam int NUM_TIMERS  = 25;
   localparam int COUNT_BITS  = 16;
   localparam int TIMER_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // word field widths
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 5;
   localparam int LOAD_W   = 16;
   localparam int FLAGS_W  = 25;
   localparam int COUNT_W  = 16;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   // output register occupancy
   typedef enum logic {
      ST_EMPTY = 1'b0,
      ST_FULL  = 1'b1
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic step;
      logic do_tick;
      logic do_load;
      logic do_clear;
   } ctrl_type;

endpackage

`default_nettype wire

// ----- hdl/ctb_if.sv -----
// ----------------------------------------------------------------------------
// ctb_req_if / ctb_rsp_if
// Valid/ready channels for request and response words of the timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctb_req_if
   import ctb_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [INDEX_W-1:0] timer_index;
   logic [LOAD_W-1:0]  load_value;

   modport source (output valid, output cmd, output timer_index, output load_value,
                   input ready);
   modport sink   (input valid, input cmd, input timer_index, input load_value,
                   output ready);
endinterface

interface ctb_rsp_if
   import ctb_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [FLAGS_W-1:0] expiry_flags;
   logic [COUNT_W-1:0] timer_count;

   modport source (output valid, output expiry_flags, output timer_count, input ready);
   modport sink   (input valid, input expiry_flags, input timer_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/ctb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ctb_ctrl
// Handshake controller: tracks the response register and decodes commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_ctrl
   import ctb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [CMD_W-1:0] req_cmd,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ctrl_type              ctrl
);

   state_type state_ff;
   state_type state_in;
   cmd_type   cmd;
   logic      accept;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and command decode
   always_comb begin
      cmd       = cmd_type'(req_cmd);
      rsp_valid = (state_ff == ST_FULL);
      req_ready = (state_ff == ST_EMPTY) || rsp_ready;
      accept    = req_valid && req_ready;
      state_in  = state_ff;
      unique case (state_ff)
         ST_EMPTY: begin
            if (accept) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (rsp_ready && !accept) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
      ctrl.step     = accept;
      ctrl.do_tick  = 1'b0;
      ctrl.do_load  = 1'b0;
      ctrl.do_clear = 1'b0;
      unique case (cmd)
         CMD_TICK:  ctrl.do_tick  = accept;
         CMD_LOAD:  ctrl.do_load  = accept;
         CMD_CLEAR: ctrl.do_clear = accept;
         CMD_READ:  ;
         default:   ;
      endcase
   end

`ifndef ASSERT_OFF
   // an accepted word always yields a pending response
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |=> rsp_valid)
      else $error("accepted word produced no response");

   // response drops only after it was taken
   a_rsp_drop_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("pending response lost");

   // at most one operation per word
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.do_tick, ctrl.do_load, ctrl.do_clear}))
      else $error("several operations decoded at once");

   // operations only on accepted words
   a_op_needs_step: assert property (@(posedge clock) disable iff (reset)
      (ctrl.do_tick || ctrl.do_load || ctrl.do_clear) |-> ctrl.step)
      else $error("operation without accepted word");
`endif

endmodule

`default_nettype wire

// ----- hdl/ctb_dpath.sv -----
// ----------------------------------------------------------------------------
// ctb_dpath
// Timer registers, expiry flags and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_dpath
   import ctb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctrl_type           ctrl,
   input  wire logic [INDEX_W-1:0] req_timer_index,
   input  wire logic [LOAD_W-1:0]  req_load_value,
   output logic [FLAGS_W-1:0]      rsp_expiry_flags,
   output logic [COUNT_W-1:0]      rsp_count
);

   localparam logic [INDEX_W:0] INDEX_LIMIT = (INDEX_W+1)'(NUM_TIMERS);

   logic [COUNT_BITS-1:0] count_ff [NUM_TIMERS];
   logic [COUNT_BITS-1:0] count_in [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] expired_ff;
   logic [NUM_TIMERS-1:0] expired_in;
   logic [FLAGS_W-1:0]    flags_ff;
   logic [COUNT_W-1:0]    rcount_ff;
   logic [COUNT_W-1:0]    rcount_in;
   logic                  index_ok;
   logic [TIMER_IDX_W-1:0] sel;
   logic [COUNT_BITS-1:0] load_count;

   // address check and narrowed load value
   always_comb begin
      index_ok   = ({1'b0, req_timer_index} < INDEX_LIMIT);
      sel        = TIMER_IDX_W'(req_timer_index);
      load_count = COUNT_BITS'(req_load_value);
   end

   // per timer update: tick, load, flag set and clear
   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         count_in[i]   = count_ff[i];
         expired_in[i] = expired_ff[i];
         if (ctrl.do_tick && (count_ff[i] != '0)) begin
            count_in[i] = count_ff[i] - COUNT_BITS'(1);
            if (count_ff[i] == COUNT_BITS'(1)) expired_in[i] = 1'b1;
         end
         if (ctrl.do_load && index_ok && (sel == TIMER_IDX_W'(i))) begin
            count_in[i] = load_count;
         end
         if (ctrl.do_clear && index_ok && (sel == TIMER_IDX_W'(i))) begin
            expired_in[i] = 1'b0;
         end
      end
      rcount_in = index_ok ? COUNT_W'(count_in[sel]) : '0;
   end

   // bank state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) count_ff[i] <= '0;
         expired_ff <= '0;
      end else if (ctrl.step) begin
         for (int i = 0; i < NUM_TIMERS; i++) count_ff[i] <= count_in[i];
         expired_ff <= expired_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         flags_ff  <= FLAGS_W'(expired_in);
         rcount_ff <= rcount_in;
      end
   end

   assign rsp_expiry_flags = flags_ff;
   assign rsp_count        = rcount_ff;

`ifndef ASSERT_OFF
   // flags rise only on a tick
   a_flag_set_on_tick: assert property (@(posedge clock) disable iff (reset)
      !ctrl.do_tick |=> (expired_ff & ~$past(expired_ff)) == '0)
      else $error("expiry flag set without tick");

   // bank holds when no word is accepted
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !ctrl.step |=> $stable(expired_ff))
      else $error("flags changed while idle");

   // response flags follow the bank
   a_rsp_flags_match: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |=> rsp_expiry_flags == FLAGS_W'(expired_ff))
      else $error("response flags differ from bank");
`endif

endmodule

`default_nettype wire

// ----- hdl/countdown_timer_bank_unit.sv -----
// ----------------------------------------------------------------------------
// countdown_timer_bank_unit
// Bank of countdown timers with expiry flags behind valid/ready channels.
// ----------------------------------------------------------------------------
// Every request word (tick, load, clear or read) is executed in the cycle it
// is accepted and gives one response word with the whole flag bitmap and the
// addressed timer's count after the step. All timers sit in registers and
// update in parallel, so one word is taken each cycle unless a response waits;
// the response register lets a new word in during the same cycle the previous
// response is taken. Beyond-bank indexes skip load/clear and report count zero.
`default_nettype none

module countdown_timer_bank_unit
   import ctb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ctb_req_if.sink   req_bus,
   ctb_rsp_if.source rsp_bus
);

   ctrl_type ctrl;

   // handshake controller
   ctb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_cmd   (req_bus.cmd),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctrl      (ctrl)
   );

   // timer datapath
   ctb_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_timer_index  (req_bus.timer_index),
      .req_load_value   (req_bus.load_value),
      .rsp_expiry_flags (rsp_bus.expiry_flags),
      .rsp_count        (rsp_bus.timer_count)
   );

endmodule

`default_nettype wire
